@@ rtl/pfe_pkg.sv @@
// Shared types, constants and square lookup functions for the Playfair encryptor.
package pfe_pkg;

  localparam int SquareDim  = 5;
  localparam int LetterW    = 5;
  localparam int IdxW       = $clog2(SquareDim);
  localparam int RowW       = SquareDim * LetterW;
  localparam int CfgIndexW  = 3;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [SquareDim-1:0][SquareDim-1:0][LetterW-1:0] key_square_t;

  typedef enum logic [CfgIndexW-1:0] {
    CfgRowZero  = 3'd0,
    CfgRowOne   = 3'd1,
    CfgRowTwo   = 3'd2,
    CfgRowThree = 3'd3,
    CfgRowFour  = 3'd4,
    CfgFiller   = 3'd5
  } cfg_reg_e;

  localparam key_square_t KeyReset = {
    25'd2149955, 25'd6848868, 25'd25942713, 25'd17283508, 25'd10755244
  };
  localparam letter_t FillerReset = 5'd23;

  typedef struct packed {
    letter_t plain_letter;
    logic    message_end;
  } in_t;

  typedef struct packed {
    letter_t cipher_letter;
    logic    last_of_run;
    logic    letter_missing;
  } out_t;

  // one digraph; twice marks a doubled final letter sent as two identical pairs
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    twice;
  } job_t;

  typedef struct packed {
    logic vld;
    job_t job;
  } job_req_t;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  typedef struct packed {
    letter_t x;
    letter_t y;
    logic    miss;
  } pair_t;

  function automatic idx_t idx_next(idx_t i);
    idx_t res;
    res = (i == idx_t'(SquareDim - 1)) ? '0 : i + idx_t'(1);
    return res;
  endfunction

  // first occurrence wins: scan from the far end so lower positions overwrite
  function automatic loc_t locate(letter_t l, key_square_t sq);
    loc_t res;
    res = '0;
    for (int r = SquareDim - 1; r >= 0; r--) begin
      for (int c = SquareDim - 1; c >= 0; c--) begin
        if (sq[r][c] == l) begin
          res.found = 1'b1;
          res.row   = idx_t'(r);
          res.col   = idx_t'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic pair_t encrypt_pair(letter_t a, letter_t b, key_square_t sq);
    loc_t  la;
    loc_t  lb;
    pair_t res;
    la = locate(a, sq);
    lb = locate(b, sq);
    res.miss = !(la.found && lb.found);
    if (res.miss) begin
      res.x = a;
      res.y = b;
    end else if (la.row == lb.row) begin
      res.x = sq[la.row][idx_next(la.col)];
      res.y = sq[lb.row][idx_next(lb.col)];
    end else if (la.col == lb.col) begin
      res.x = sq[idx_next(la.row)][la.col];
      res.y = sq[idx_next(lb.row)][lb.col];
    end else begin
      res.x = sq[la.row][lb.col];
      res.y = sq[lb.row][la.col];
    end
    return res;
  endfunction

endpackage

@@ rtl/pfe_front.sv @@
// Front end: holds the pending letter and turns letters into digraph jobs.
module pfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfe_pkg::in_t      in_data,
  input  pfe_pkg::letter_t  filler,
  input  logic              fifo_full,
  output pfe_pkg::job_req_t job_req
);

  logic             pend_valid_r;
  logic             pend_valid_nxt;
  pfe_pkg::letter_t pend_letter_r;
  pfe_pkg::letter_t pend_letter_nxt;
  logic             accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    job_req         = '0;
    if (accept) begin
      if (!pend_valid_r) begin
        if (in_data.message_end) begin
          job_req.vld   = 1'b1;
          job_req.job.a = in_data.plain_letter;
          job_req.job.b = filler;
        end else begin
          pend_valid_nxt  = 1'b1;
          pend_letter_nxt = in_data.plain_letter;
        end
      end else if (in_data.plain_letter != pend_letter_r) begin
        job_req.vld    = 1'b1;
        job_req.job.a  = pend_letter_r;
        job_req.job.b  = in_data.plain_letter;
        pend_valid_nxt = 1'b0;
      end else begin
        job_req.vld       = 1'b1;
        job_req.job.a     = pend_letter_r;
        job_req.job.b     = filler;
        job_req.job.twice = in_data.message_end;
        pend_valid_nxt    = !in_data.message_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
    end else begin
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
    end
  end

endmodule

@@ rtl/pfe_fifo.sv @@
// Short job queue between the front end and the cipher back end.
module pfe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::job_req_t push,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output pfe_pkg::job_t     head
);

  pfe_pkg::job_t                 mem_r [pfe_pkg::FifoDepth];
  logic [pfe_pkg::FifoPtrW-1:0]  wr_ptr_r;
  logic [pfe_pkg::FifoPtrW-1:0]  wr_ptr_nxt;
  logic [pfe_pkg::FifoPtrW-1:0]  rd_ptr_r;
  logic [pfe_pkg::FifoPtrW-1:0]  rd_ptr_nxt;
  logic [pfe_pkg::FifoPtrW:0]    count_r;
  logic [pfe_pkg::FifoPtrW:0]    count_nxt;

  assign full  = (count_r == (pfe_pkg::FifoPtrW+1)'(pfe_pkg::FifoDepth));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.vld && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.vld && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/pfe_back.sv @@
// Back end: encrypts one digraph job and sends its letters one beat at a time.
module pfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfe_pkg::key_square_t key_sq,
  input  logic                 fifo_valid,
  input  pfe_pkg::job_t        fifo_head,
  output logic                 fifo_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfe_pkg::out_t        out_data
);

  pfe_pkg::job_t  job_r;
  pfe_pkg::job_t  job_nxt;
  logic           job_valid_r;
  logic           job_valid_nxt;
  logic [1:0]     beat_r;
  logic [1:0]     beat_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  pfe_pkg::out_t  out_data_r;
  pfe_pkg::out_t  out_data_nxt;
  pfe_pkg::pair_t pair;
  logic           beat_last;
  logic           load;
  logic           job_done;

  assign pair      = pfe_pkg::encrypt_pair(job_r.a, job_r.b, key_sq);
  assign beat_last = job_r.twice ? (beat_r == 2'd3) : (beat_r == 2'd1);
  assign load      = job_valid_r && (!out_valid_r || out_ready);
  assign job_done  = load && beat_last;
  assign fifo_pop  = fifo_valid && (!job_valid_r || job_done);

  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    beat_nxt      = beat_r;
    if (fifo_pop) begin
      job_nxt       = fifo_head;
      job_valid_nxt = 1'b1;
      beat_nxt      = '0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (load) begin
      beat_nxt = beat_r + 2'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.cipher_letter  = beat_r[0] ? pair.y : pair.x;
      out_data_nxt.last_of_run    = beat_last;
      out_data_nxt.letter_missing = pair.miss;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/playfair_digraph_encrypt.sv @@
// Top level: Playfair digraph encryptor with key square and filler registers.
// The closing letter's digraph passes the queue, the job register and the output register
// before its first cipher letter leaves, the second following it; a lone pending letter gives no beat.
// Throughput: one letter and one result beat per cycle while out_ready holds; a doubled
// letter closes a digraph alone, so runs of them fill the 4-entry queue and input drops to one letter in two.
// Reset: synchronous, active low; clears pending letter, queue and output; reset square and filler.
module playfair_digraph_encrypt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pfe_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfe_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [pfe_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pfe_pkg::RowW-1:0]      cfg_wdata
);

  pfe_pkg::key_square_t key_sq_r;
  pfe_pkg::key_square_t key_sq_nxt;
  pfe_pkg::letter_t     filler_r;
  pfe_pkg::letter_t     filler_nxt;
  pfe_pkg::job_req_t    job_req;
  pfe_pkg::job_t        fifo_head;
  logic                 fifo_full;
  logic                 fifo_valid;
  logic                 fifo_pop;

  always_comb begin
    key_sq_nxt = key_sq_r;
    filler_nxt = filler_r;
    if (cfg_we) begin
      case (cfg_index)
        pfe_pkg::CfgRowZero:  key_sq_nxt[0] = cfg_wdata;
        pfe_pkg::CfgRowOne:   key_sq_nxt[1] = cfg_wdata;
        pfe_pkg::CfgRowTwo:   key_sq_nxt[2] = cfg_wdata;
        pfe_pkg::CfgRowThree: key_sq_nxt[3] = cfg_wdata;
        pfe_pkg::CfgRowFour:  key_sq_nxt[4] = cfg_wdata;
        pfe_pkg::CfgFiller:   filler_nxt    = cfg_wdata[pfe_pkg::LetterW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_sq_r <= pfe_pkg::KeyReset;
      filler_r <= pfe_pkg::FillerReset;
    end else begin
      key_sq_r <= key_sq_nxt;
      filler_r <= filler_nxt;
    end
  end

  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .filler    (filler_r),
    .fifo_full (fifo_full),
    .job_req   (job_req)
  );

  pfe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_req),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .valid (fifo_valid),
    .head  (fifo_head)
  );

  pfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_sq     (key_sq_r),
    .fifo_valid (fifo_valid),
    .fifo_head  (fifo_head),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_req.vld |-> !fifo_full)
    else $error("job pushed into full queue");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> fifo_valid)
    else $error("job popped from empty queue");

  a_out_idle_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result beat straight after reset");

  a_lone_letter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !job_req.vld) |-> !in_data.message_end)
    else $error("final letter produced no digraph");

endmodule
